[rtl/odo_pkg.sv]
// ----------------------------------------------------------------------------
// odo_pkg
// shared constants, state types and the cordic arctangent table for the
// differential drive odometry block
// ----------------------------------------------------------------------------
package odo_pkg;

    // encoder geometry and trig precision
    localparam int ENCODER_COUNTS = 128;
    localparam int ENC_BITS       = $clog2(ENCODER_COUNTS);
    localparam int ENC_HALF       = ENCODER_COUNTS / 2;
    localparam int TRIG_BITS      = 16;

    // cordic
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_W     = 33;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int CORDIC_SH    = 31 - TRIG_BITS;
    localparam int SC_W         = TRIG_BITS + 1;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;

    // datapath widths
    localparam int DIST_W   = 16;
    localparam int HEAD_W   = 12;
    localparam int DELTA_W  = ENC_BITS + 1;
    localparam int SUM_W    = DELTA_W + 1;
    localparam int TRAVEL_W = SUM_W + DIST_W;
    localparam int MUL_A_W  = TRAVEL_W;
    localparam int MUL_B_W  = (SC_W > DIST_W + 1) ? SC_W : DIST_W + 1;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int POS_W    = 32;
    localparam int ANG_W    = 16;
    localparam int ROUND_W  = 16;

    // register defaults
    localparam logic [DIST_W-1:0] DIST_RESET = 16'd1056;
    localparam logic [HEAD_W-1:0] HEAD_RESET = 12'd156;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_PER_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_PER_DIFF  = 1'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UNWRAP,
        ST_TURN,
        ST_TRAVEL,
        ST_TRIG_START,
        ST_TRIG_WAIT,
        ST_MUL_X,
        ST_MUL_Y,
        ST_ACC_Y,
        ST_OUT
    } t_odo_state;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_ITER,
        CS_ROUND
    } t_cordic_state;

    // atan(2^-i) as a fraction of a 32 bit turn
    function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000003;
            5'd29:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

[rtl/odo_cordic.sv]
// ----------------------------------------------------------------------------
// odo_cordic
// iterative rotation-mode cordic: one shift-add micro-rotation per cycle,
// gives sine and cosine of a 16 bit binary angle rounded to TRIG_BITS
// ----------------------------------------------------------------------------
module odo_cordic (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [odo_pkg::ANG_W-1:0]        i_angle,
    output logic                             o_done,
    output logic signed [odo_pkg::SC_W-1:0]  o_sin,
    output logic signed [odo_pkg::SC_W-1:0]  o_cos
);
    import odo_pkg::*;

    localparam logic signed [CORDIC_W-1:0] RND_HALF = CORDIC_W'(1) <<< (CORDIC_SH - 1);

    t_cordic_state r_state, n_state;
    logic [STEP_W-1:0]          r_step, n_step;
    logic                       r_flip, n_flip;
    logic                       r_done, n_done;
    logic signed [CORDIC_W-1:0] r_x, n_x, r_y, n_y, r_z, n_z;
    logic signed [SC_W-1:0]     r_sin, n_sin, r_cos, n_cos;

    logic [31:0]                turn;
    logic                       quad_flip;
    logic signed [CORDIC_W-1:0] xs, ys, atan_v, x_rnd, y_rnd;
    logic signed [SC_W-1:0]     x_out, y_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_step <= n_step;
        r_flip <= n_flip;
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_sin  <= n_sin;
        r_cos  <= n_cos;
    end

    always_comb begin
        turn      = {i_angle, 16'd0};
        quad_flip = (turn[31:30] == 2'd1) || (turn[31:30] == 2'd2);
        xs        = r_x >>> r_step;
        ys        = r_y >>> r_step;
        atan_v    = signed'({1'b0, atan_turn(r_step)});
        x_rnd     = (r_x + RND_HALF) >>> CORDIC_SH;
        y_rnd     = (r_y + RND_HALF) >>> CORDIC_SH;
        x_out     = r_flip ? -x_rnd[SC_W-1:0] : x_rnd[SC_W-1:0];
        y_out     = r_flip ? -y_rnd[SC_W-1:0] : y_rnd[SC_W-1:0];

        n_state = r_state;
        n_step  = r_step;
        n_flip  = r_flip;
        n_done  = 1'b0;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_sin   = r_sin;
        n_cos   = r_cos;

        case (r_state)
            CS_IDLE: begin
                if (i_start) begin
                    // fold the left half plane onto the right one
                    n_flip  = quad_flip;
                    n_z     = CORDIC_W'(signed'({turn[31] ^ quad_flip, turn[30:0]}));
                    n_x     = CORDIC_GAIN;
                    n_y     = '0;
                    n_step  = '0;
                    n_state = CS_ITER;
                end
            end
            CS_ITER: begin
                if (!r_z[CORDIC_W-1]) begin
                    n_x = r_x - ys;
                    n_y = r_y + xs;
                    n_z = r_z - atan_v;
                end else begin
                    n_x = r_x + ys;
                    n_y = r_y - xs;
                    n_z = r_z + atan_v;
                end
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                    n_state = CS_ROUND;
                end
            end
            CS_ROUND: begin
                n_cos   = x_out;
                n_sin   = y_out;
                n_done  = 1'b1;
                n_state = CS_IDLE;
            end
            default: begin
                n_state = CS_IDLE;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_sin  = r_sin;
    assign o_cos  = r_cos;

endmodule

[rtl/differential_drive_odometry.sv]
// ----------------------------------------------------------------------------
// differential_drive_odometry
// dead-reckoning odometry for a two wheel robot from absolute encoder counts
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one item per encoder sample: tdata[6:0] left count,
//   tdata[13:7] right count. m_axis returns one item per sample with the
//   updated pose and wheel revolution counters.
//   the config port writes distance per count (index 0) and heading per
//   count of wheel difference (index 1); write only while the block is idle.
// sequencing
//   one item at a time: a new input item is taken once the last result is in
//   the output register; each item runs the 30 micro-rotations of the cordic
//   unit and passes through the one shared 25x17 multiplier and accumulation.
// reset
//   pose, turn counters and last encoder counts clear to zero, the config
//   registers return to their defaults.
// stall
//   a result waits in the output register while m_axis_tready is low; the
//   next input item is still taken, and its result waits until that slot
//   is free.
// ----------------------------------------------------------------------------
module differential_drive_odometry (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // s_axis tdata: left_wheel_count[6:0], right_wheel_count[13:7]
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [15:0]                       s_axis_tdata,
    // m_axis tdata: x_position[31:0], y_position[63:32], heading[79:64],
    //               left_turns[95:80], right_turns[111:96]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [111:0]                      m_axis_tdata,
    input  logic                              i_cfg_wr_en,
    input  logic [odo_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [odo_pkg::DIST_W-1:0]        i_cfg_data
);
    import odo_pkg::*;

    localparam logic signed [PROD_W-1:0] OUT_HALF = PROD_W'(1) <<< (TRIG_BITS - 1);

    t_odo_state r_state, n_state;

    logic [DIST_W-1:0]         r_dist;
    logic [HEAD_W-1:0]         r_head_gain;
    logic [ENC_BITS-1:0]       r_in_l, r_in_r, r_last_l, r_last_r;
    logic signed [DELTA_W-1:0] r_dl, r_dr;
    logic [ROUND_W-1:0]        r_rounds_l, r_rounds_r;
    logic [ANG_W-1:0]          r_heading;
    logic [POS_W-1:0]          r_pos_x, r_pos_y;
    logic signed [TRAVEL_W-1:0] r_travel;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_out_valid;
    logic [111:0]              r_out_data;

    logic signed [DELTA_W-1:0] dl_raw, dr_raw, dl, dr;
    logic                      wl_fwd, wl_back, wr_fwd, wr_back;
    logic signed [DELTA_W:0]   wheel_diff, wheel_sum;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  step_rnd;
    logic                      trig_start, trig_done;
    logic signed [SC_W-1:0]    trig_sin, trig_cos;
    logic                      accept_in, load_out;

    odo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (trig_start),
        .i_angle (r_heading),
        .o_done  (trig_done),
        .o_sin   (trig_sin),
        .o_cos   (trig_cos)
    );

    // wheel change unwrapped into -half..+half
    always_comb begin
        dl_raw  = signed'({1'b0, r_in_l}) - signed'({1'b0, r_last_l});
        dr_raw  = signed'({1'b0, r_in_r}) - signed'({1'b0, r_last_r});
        wl_back = dl_raw >  DELTA_W'(ENC_HALF);
        wl_fwd  = dl_raw < -DELTA_W'(ENC_HALF);
        wr_back = dr_raw >  DELTA_W'(ENC_HALF);
        wr_fwd  = dr_raw < -DELTA_W'(ENC_HALF);
        dl = dl_raw;
        dr = dr_raw;
        if (wl_back) dl = dl_raw - DELTA_W'(ENCODER_COUNTS);
        if (wl_fwd)  dl = dl_raw + DELTA_W'(ENCODER_COUNTS);
        if (wr_back) dr = dr_raw - DELTA_W'(ENCODER_COUNTS);
        if (wr_fwd)  dr = dr_raw + DELTA_W'(ENCODER_COUNTS);
    end

    assign wheel_diff = (DELTA_W+1)'(r_dr) - (DELTA_W+1)'(r_dl);
    assign wheel_sum  = (DELTA_W+1)'(r_dr) + (DELTA_W+1)'(r_dl);
    assign step_rnd   = (r_prod + OUT_HALF) >>> TRIG_BITS;

    assign accept_in     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);

    // shared multiplier operand select
    always_comb begin
        mul_a = MUL_A_W'(wheel_sum);
        mul_b = signed'(MUL_B_W'({1'b0, r_dist}));
        case (r_state)
            ST_TURN: begin
                mul_a = MUL_A_W'(wheel_diff);
                mul_b = signed'(MUL_B_W'({1'b0, r_head_gain}));
            end
            ST_MUL_X: begin
                mul_a = r_travel;
                mul_b = MUL_B_W'(trig_sin);
            end
            ST_MUL_Y: begin
                mul_a = r_travel;
                mul_b = MUL_B_W'(trig_cos);
            end
            default: begin
                mul_a = MUL_A_W'(wheel_sum);
                mul_b = signed'(MUL_B_W'({1'b0, r_dist}));
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        trig_start = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            ST_IDLE:       if (accept_in) n_state = ST_UNWRAP;
            ST_UNWRAP:     n_state = ST_TURN;
            ST_TURN:       n_state = ST_TRAVEL;
            ST_TRAVEL:     n_state = ST_TRIG_START;
            ST_TRIG_START: begin
                trig_start = 1'b1;
                n_state    = ST_TRIG_WAIT;
            end
            ST_TRIG_WAIT:  if (trig_done) n_state = ST_MUL_X;
            ST_MUL_X:      n_state = ST_MUL_Y;
            ST_MUL_Y:      n_state = ST_ACC_Y;
            ST_ACC_Y:      n_state = ST_OUT;
            ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default:       n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_dist      <= DIST_RESET;
            r_head_gain <= HEAD_RESET;
            r_last_l    <= '0;
            r_last_r    <= '0;
            r_rounds_l  <= '0;
            r_rounds_r  <= '0;
            r_heading   <= '0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_DIST_PER_COUNT: r_dist      <= i_cfg_data;
                    CFG_HEAD_PER_DIFF:  r_head_gain <= i_cfg_data[HEAD_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == ST_UNWRAP) begin
                r_last_l <= r_in_l;
                r_last_r <= r_in_r;
                // right counter steps opposite to its wrap, reversed mounting
                if (wl_fwd)  r_rounds_l <= r_rounds_l + 1'b1;
                if (wl_back) r_rounds_l <= r_rounds_l - 1'b1;
                if (wr_fwd)  r_rounds_r <= r_rounds_r - 1'b1;
                if (wr_back) r_rounds_r <= r_rounds_r + 1'b1;
            end
            if (r_state == ST_TRAVEL) begin
                r_heading <= r_heading - r_prod[ANG_W-1:0];
            end
            if (r_state == ST_MUL_Y) begin
                r_pos_x <= r_pos_x + step_rnd[POS_W-1:0];
            end
            if (r_state == ST_ACC_Y) begin
                r_pos_y <= r_pos_y + step_rnd[POS_W-1:0];
            end
        end
        if (accept_in) begin
            r_in_l <= s_axis_tdata[ENC_BITS-1:0];
            r_in_r <= s_axis_tdata[2*ENC_BITS-1:ENC_BITS];
        end
        if (r_state == ST_UNWRAP) begin
            r_dl <= dl;
            r_dr <= -dr;
        end
        if (r_state == ST_TRIG_START) begin
            r_travel <= r_prod[TRAVEL_W-1:0];
        end
        r_prod <= mul_a * mul_b;
        if (load_out) begin
            r_out_data <= {r_rounds_r, r_rounds_l, r_heading, r_pos_y, r_pos_x};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

[tb/sv/differential_drive_odometry_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_test
// Self-checking bench for the odometry block. Encoder samples go in on the
// slave stream and each pose item on the master stream is checked against
// a local pose tracker: wheel unwrap and turn counters, binary-angle
// heading and cordic-based x/y dead reckoning. A directed list comes first,
// then random drives under several distance and heading gains, including
// zero and full-scale ones, with random gaps and stalls on both streams and
// one long output hold-off.
// ----------------------------------------------------------------------------
module differential_drive_odometry_test;
    import odo_pkg::*;

    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int DRAIN_CYCLES = 60;
    localparam int MAX_PRINTS   = 40;
    localparam int N_DIRECTED   = 22;

    localparam logic [31:0] ATAN_TURN [0:29] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] hdg;
        logic [15:0] lt;
        logic [15:0] rt;
    } pose_t;

    typedef struct packed {
        logic [6:0] left;
        logic [6:0] right;
        logic       typed;
        pose_t      want;
    } wheel_row_t;

    // pure turns and wraps have poses that follow directly from the counts
    localparam wheel_row_t DIRECTED [N_DIRECTED] = '{
        '{7'd0,   7'd0,   1'b1, '{32'd0, 32'd0, 16'd0,     16'd0,     16'd0}},
        '{7'd1,   7'd1,   1'b1, '{32'd0, 32'd0, 16'd312,   16'd0,     16'd0}},
        '{7'd127, 7'd127, 1'b1, '{32'd0, 32'd0, 16'd65224, 16'hFFFF,  16'd1}},
        '{7'd63,  7'd63,  1'b1, '{32'd0, 32'd0, 16'd45256, 16'hFFFF,  16'd1}},
        '{7'd127, 7'd127, 1'b1, '{32'd0, 32'd0, 16'd65224, 16'hFFFF,  16'd1}},
        '{7'd0,   7'd0,   1'b1, '{32'd0, 32'd0, 16'd0,     16'd0,     16'd0}},
        '{7'd20,  7'd108, 1'b0, '0},
        '{7'd40,  7'd88,  1'b0, '0},
        '{7'd104, 7'd24,  1'b0, '0},
        '{7'd40,  7'd88,  1'b0, '0},
        '{7'd72,  7'd72,  1'b0, '0},
        '{7'd100, 7'd60,  1'b0, '0},
        '{7'd127, 7'd0,   1'b0, '0},
        '{7'd0,   7'd127, 1'b0, '0},
        '{7'd85,  7'd42,  1'b0, '0},
        '{7'd42,  7'd85,  1'b0, '0},
        '{7'd127, 7'd127, 1'b0, '0},
        '{7'd0,   7'd0,   1'b0, '0},
        '{7'd64,  7'd64,  1'b0, '0},
        '{7'd0,   7'd64,  1'b0, '0},
        '{7'd64,  7'd0,   1'b0, '0},
        '{7'd1,   7'd127, 1'b0, '0}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [111:0]         m_axis_tdata;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_DIST_PER_COUNT;
    logic [DIST_W-1:0]    i_cfg_data = '0;

    // tracked pose and gains
    logic [6:0]  last_left;
    logic [6:0]  last_right;
    logic [15:0] rounds_left;
    logic [15:0] rounds_right;
    logic [15:0] heading_ang;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [15:0] gain_dist;
    logic [11:0] gain_head;

    pose_t expected_poses [$];
    pose_t got_pose;
    pose_t want_pose;

    int  errors = 0;
    int  n_items = 0;
    int  n_results = 0;
    int  n_wraps = 0;
    int  n_settings = 1;
    int  cycle_cnt = 0;
    int  hold_req = 0;
    int  stall_cnt = 0;
    int  roll;
    bit  calm = 1'b0;

    differential_drive_odometry i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
                     expected_poses.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("result %0d %s: got %h, expected %h", n_results, what, got, want);
    endtask

    function automatic int unwrap_count(input logic [6:0] cur, input logic [6:0] prev,
                                        output int wrap);
        int d;
        d = int'(cur) - int'(prev);
        wrap = 0;
        if (d > ENC_HALF) begin
            d -= ENCODER_COUNTS;
            wrap = -1;
        end
        if (d < -ENC_HALF) begin
            d += ENCODER_COUNTS;
            wrap = 1;
        end
        return d;
    endfunction

    // cordic on the heading, folded into the right half plane
    task automatic heading_sin_cos(input logic [15:0] ang, output longint sn,
                                   output longint cs);
        logic [31:0] a;
        bit          flip;
        longint      x, y, z, nx, xs, ys;
        a = {ang, 16'h0000};
        flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
        if (flip)
            a = a + 32'h8000_0000;
        z = longint'($signed(a));
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < 30; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                nx = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_TURN[i]);
            end else begin
                nx = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_TURN[i]);
            end
            x = nx;
        end
        x = (x + 64'sd16384) >>> 15;
        y = (y + 64'sd16384) >>> 15;
        if (flip) begin
            x = -x;
            y = -y;
        end
        sn = y;
        cs = x;
    endtask

    task automatic reset_tracker();
        last_left = '0;
        last_right = '0;
        rounds_left = '0;
        rounds_right = '0;
        heading_ang = '0;
        pos_x = '0;
        pos_y = '0;
        gain_dist = 16'd1056;
        gain_head = 12'd156;
    endtask

    task automatic predict_pose(input logic [6:0] l, input logic [6:0] r, output pose_t p);
        int     dl, dr, wl, wr, turn;
        longint travel, sn, cs, dx, dy;
        dl = unwrap_count(l, last_left, wl);
        dr = unwrap_count(r, last_right, wr);
        if (wl != 0 || wr != 0)
            n_wraps++;
        last_left = l;
        last_right = r;
        rounds_left = rounds_left + 16'(wl);
        rounds_right = rounds_right - 16'(wr);
        // right motor is mounted reversed
        dr = -dr;
        turn = (dr - dl) * int'(gain_head);
        heading_ang = heading_ang - turn[15:0];
        travel = longint'(dl + dr) * longint'(gain_dist);
        heading_sin_cos(heading_ang, sn, cs);
        dx = (travel * sn + 64'sd32768) >>> 16;
        dy = (travel * cs + 64'sd32768) >>> 16;
        pos_x = pos_x + dx[31:0];
        pos_y = pos_y + dy[31:0];
        p.x = pos_x;
        p.y = pos_y;
        p.hdg = heading_ang;
        p.lt = rounds_left;
        p.rt = rounds_right;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 4);
        if (r < 97)
            return $urandom_range(5, 45);
        return $urandom_range(46, 120);
    endfunction

    task automatic send_item(input logic [6:0] l, input logic [6:0] r, input logic typed,
                             input pose_t want);
        int    gap;
        pose_t p;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, r, l};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_pose(l, r, p);
        expected_poses.push_back(typed ? want : p);
        n_items++;
    endtask

    // mostly small and straight moves, some half-turn jumps and raw noise
    task automatic pick_sample(output logic [6:0] l, output logic [6:0] r);
        int kind, s;
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
            l = last_left + 7'(int'($urandom_range(0, 24)) - 12);
            r = last_right + 7'(int'($urandom_range(0, 24)) - 12);
        end else if (kind < 70) begin
            s = int'($urandom_range(0, 40)) - 20;
            l = last_left + 7'(s);
            r = last_right - 7'(s);
        end else if (kind < 80) begin
            s = int'($urandom_range(63, 65));
            l = last_left + 7'($urandom_range(0, 1) ? s : -s);
            s = int'($urandom_range(63, 65));
            r = last_right + 7'($urandom_range(0, 1) ? s : -s);
        end else begin
            l = 7'($urandom);
            r = 7'($urandom);
        end
    endtask

    task automatic run_random(input int n, input int calm_n);
        logic [6:0] l, r;
        for (int i = 0; i < n; i++) begin
            calm = (i < calm_n);
            pick_sample(l, r);
            send_item(l, r, 1'b0, '0);
        end
        calm = 1'b0;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_poses.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_gains(input logic [15:0] dist_set, input logic [15:0] head);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_DIST_PER_COUNT;
        i_cfg_data <= dist_set;
        @(posedge i_clk);
        i_cfg_index <= CFG_HEAD_PER_DIFF;
        i_cfg_data <= head;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        gain_dist = dist_set;
        gain_head = head[11:0];
        n_settings++;
    endtask

    // output side: random ready, short stalls and requested long holds
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                stall_cnt = hold_req;
                hold_req = 0;
            end
            if (stall_cnt > 0) begin
                stall_cnt--;
                m_axis_tready <= 1'b0;
            end else if (calm) begin
                m_axis_tready <= 1'b1;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 3) begin
                    stall_cnt = $urandom_range(10, 80);
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= (roll >= 28);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_pose.x = m_axis_tdata[31:0];
            got_pose.y = m_axis_tdata[63:32];
            got_pose.hdg = m_axis_tdata[79:64];
            got_pose.lt = m_axis_tdata[95:80];
            got_pose.rt = m_axis_tdata[111:96];
            n_results++;
            if (expected_poses.size() == 0) begin
                report_mismatch("item with no pose pending", got_pose.x, 32'd0);
            end else begin
                want_pose = expected_poses.pop_front();
                if (got_pose.x !== want_pose.x)
                    report_mismatch("x_position", got_pose.x, want_pose.x);
                if (got_pose.y !== want_pose.y)
                    report_mismatch("y_position", got_pose.y, want_pose.y);
                if (got_pose.hdg !== want_pose.hdg)
                    report_mismatch("heading", got_pose.hdg, want_pose.hdg);
                if (got_pose.lt !== want_pose.lt)
                    report_mismatch("left_turns", got_pose.lt, want_pose.lt);
                if (got_pose.rt !== want_pose.rt)
                    report_mismatch("right_turns", got_pose.rt, want_pose.rt);
            end
        end
    end

    initial begin
        reset_tracker();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_item(DIRECTED[i].left, DIRECTED[i].right, DIRECTED[i].typed,
                      DIRECTED[i].want);
        run_random(200, 0);

        wait_idle();
        apply_gains(16'hFFFF, 16'h0FFF);
        run_random(215, 0);

        wait_idle();
        apply_gains(16'd1, 16'd1);
        run_random(215, 40);

        // zero gains: no travel, no turning
        wait_idle();
        apply_gains(16'd0, 16'd0);
        run_random(215, 0);

        // upper bits of the heading gain are dropped
        wait_idle();
        apply_gains(16'($urandom_range(1, 65535)), 16'hF000 | 16'($urandom_range(1, 4095)));
        run_random(215, 0);

        wait_idle();
        apply_gains(16'($urandom), 16'($urandom));
        run_random(215, 40);

        // hold the output long enough for the input side to back up
        wait_idle();
        apply_gains(16'd1056, 16'd156);
        hold_req = 300;
        run_random(12, 12);
        run_random(200, 0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_poses.size() != 0) begin
            errors++;
            $display("%0d expected poses never arrived", expected_poses.size());
        end

        $display("sent %0d encoder samples (%0d with a wheel wrap) over %0d gain settings",
                 n_items, n_wraps, n_settings);
        $display("checked %0d pose items, %0d mismatches", n_results, errors);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
